>>> hdl/dda_line_pixel_generator_macros.svh
// Assertion macros shared by the line rasterizer RTL.
`ifndef DDA_LINE_PIXEL_GENERATOR_MACROS_SVH
`define DDA_LINE_PIXEL_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DDA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define DDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/dda_pkg.sv
// Widths and constants of the line rasterizer.
package dda_pkg;

   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 16;

   // accumulator: sign, integer part, fraction
   localparam int ACC_W  = COORD_BITS + FRAC_BITS + 1;
   // increment: sign, one integer bit, fraction
   localparam int INC_W  = FRAC_BITS + 2;
   // step count: holds up to 2^COORD_BITS - 1 with a spare bit for deltas
   localparam int STEP_W = COORD_BITS + 1;
   // divider numerator and quotient widths
   localparam int NUM_W  = COORD_BITS + FRAC_BITS;
   localparam int QUO_W  = FRAC_BITS + 1;
   localparam int CNT_W  = $clog2(NUM_W);

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

endpackage

>>> hdl/dda_line_pixel_generator.sv
// DDA line rasterizer: start items set up a line, step items emit its pixels.
// Every item's result word is registered and shows in the cycle after accept.
// Throughput: step items go one per cycle while result words are taken; a start item with
//    distinct endpoints then holds the input off while the one shared restoring divider
//    works out the x and then the y increment, one bit a cycle.
// Reset: synchronous, active high; clears the sequencer, step count and output valid.
`include "dda_line_pixel_generator_macros.svh"

module dda_line_pixel_generator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_op,
   input  logic [dda_pkg::COORD_BITS-1:0] req_x_start,
   input  logic [dda_pkg::COORD_BITS-1:0] req_y_start,
   input  logic [dda_pkg::COORD_BITS-1:0] req_x_end,
   input  logic [dda_pkg::COORD_BITS-1:0] req_y_end,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_pixel_valid,
   output logic [dda_pkg::COORD_BITS-1:0] rsp_pixel_x,
   output logic [dda_pkg::COORD_BITS-1:0] rsp_pixel_y,
   output logic                           rsp_last_pixel
);

   import dda_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y
   } state_type;

   // Sequencer and line state
   state_type                  state_ff,      state_in;
   logic signed [ACC_W-1:0]    x_accum_ff,    x_accum_in;
   logic signed [ACC_W-1:0]    y_accum_ff,    y_accum_in;
   logic signed [INC_W-1:0]    x_incr_ff,     x_incr_in;
   logic signed [INC_W-1:0]    y_incr_ff,     y_incr_in;
   logic [STEP_W-1:0]          steps_left_ff, steps_left_in;

   // Shared divider: numerator shifts out the top while quotient bits shift in
   logic [NUM_W-1:0]           num_ff,        num_in;
   logic [COORD_BITS-1:0]      rem_ff,        rem_in;
   logic [CNT_W-1:0]           bit_cnt_ff,    bit_cnt_in;
   logic                       x_neg_ff,      x_neg_in;
   logic                       y_neg_ff,      y_neg_in;
   logic [COORD_BITS-1:0]      y_mag_ff,      y_mag_in;

   // Result word register
   logic                       rsp_valid_ff,  rsp_valid_in;
   logic                       pix_valid_ff,  pix_valid_in;
   logic [COORD_BITS-1:0]      pix_x_ff,      pix_x_in;
   logic [COORD_BITS-1:0]      pix_y_ff,      pix_y_in;
   logic                       last_ff,       last_in;

   // Combinational helpers
   logic                       req_fire;
   logic [STEP_W-1:0]          dx, dy, ax, ay, steps;
   logic [STEP_W-1:0]          trial;
   logic                       trial_ge;
   logic [NUM_W-1:0]           num_shift;
   logic [QUO_W-1:0]           quotient;
   logic signed [ACC_W-1:0]    x_sum, y_sum;

   // Rounded numerator: mag * 2^FRAC_BITS + steps / 2
   function automatic logic [NUM_W-1:0] num_load(input logic [COORD_BITS-1:0] mag,
                                                 input logic [STEP_W-1:0] div);
      return {mag, {FRAC_BITS{1'b0}}} + NUM_W'(div >> 1);
   endfunction

   function automatic logic signed [INC_W-1:0] signed_incr(input logic [QUO_W-1:0] q,
                                                           input logic neg);
      logic [INC_W-1:0] mag;
      mag = INC_W'(q);
      return neg ? -mag : mag;
   endfunction

   // Truncate toward zero, clamp negatives to column/row zero
   function automatic logic [COORD_BITS-1:0] coord_of(input logic signed [ACC_W-1:0] acc);
      return acc[ACC_W-1] ? '0 : acc[ACC_W-2:FRAC_BITS];
   endfunction

   // Accept only with the divider parked and the result slot free or draining
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      // Endpoint deltas and their magnitudes
      dx    = {1'b0, req_x_end} - {1'b0, req_x_start};
      dy    = {1'b0, req_y_end} - {1'b0, req_y_start};
      ax    = dx[STEP_W-1] ? -dx : dx;
      ay    = dy[STEP_W-1] ? -dy : dy;
      steps = (ax >= ay) ? ax : ay;

      // One restoring-division step against the step count
      trial     = {rem_ff, num_ff[NUM_W-1]};
      trial_ge  = trial >= steps_left_ff;
      num_shift = {num_ff[NUM_W-2:0], trial_ge};
      quotient  = num_shift[QUO_W-1:0];

      // Accumulator advance, sign-extending the increments
      x_sum = x_accum_ff + {{(ACC_W-INC_W){x_incr_ff[INC_W-1]}}, x_incr_ff};
      y_sum = y_accum_ff + {{(ACC_W-INC_W){y_incr_ff[INC_W-1]}}, y_incr_ff};
   end

   always_comb begin
      state_in      = state_ff;
      x_accum_in    = x_accum_ff;
      y_accum_in    = y_accum_ff;
      x_incr_in     = x_incr_ff;
      y_incr_in     = y_incr_ff;
      steps_left_in = steps_left_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      bit_cnt_in    = bit_cnt_ff;
      x_neg_in      = x_neg_ff;
      y_neg_in      = y_neg_ff;
      y_mag_in      = y_mag_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      pix_valid_in  = pix_valid_ff;
      pix_x_in      = pix_x_ff;
      pix_y_in      = pix_y_ff;
      last_in       = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // Every accepted item answers with one word
               rsp_valid_in = 1'b1;
               pix_valid_in = 1'b0;
               pix_x_in     = '0;
               pix_y_in     = '0;
               last_in      = 1'b0;
               if (req_op == OP_START) begin
                  // Load the new line, abandoning any in progress
                  x_accum_in    = ACC_W'({req_x_start, {FRAC_BITS{1'b0}}});
                  y_accum_in    = ACC_W'({req_y_start, {FRAC_BITS{1'b0}}});
                  steps_left_in = steps;
                  x_incr_in     = '0;
                  y_incr_in     = '0;
                  x_neg_in      = dx[STEP_W-1];
                  y_neg_in      = dy[STEP_W-1];
                  y_mag_in      = ay[COORD_BITS-1:0];
                  num_in        = num_load(ax[COORD_BITS-1:0], steps);
                  rem_in        = '0;
                  bit_cnt_in    = CNT_W'(NUM_W - 1);
                  // Equal endpoints: zero increments, nothing to divide
                  if (steps != '0) begin
                     state_in = ST_DIV_X;
                  end
               end else if (steps_left_ff != '0) begin
                  // Advance one pixel
                  x_accum_in    = x_sum;
                  y_accum_in    = y_sum;
                  steps_left_in = steps_left_ff - STEP_W'(1);
                  pix_valid_in  = 1'b1;
                  pix_x_in      = coord_of(x_sum);
                  pix_y_in      = coord_of(y_sum);
                  last_in       = (steps_left_ff == STEP_W'(1));
               end
            end
         end
         ST_DIV_X, ST_DIV_Y: begin
            num_in     = num_shift;
            rem_in     = trial_ge ? COORD_BITS'(trial - steps_left_ff)
                                  : trial[COORD_BITS-1:0];
            bit_cnt_in = bit_cnt_ff - CNT_W'(1);
            if (bit_cnt_ff == '0) begin
               if (state_ff == ST_DIV_X) begin
                  // Hold x result, reload the divider for y
                  x_incr_in  = signed_incr(quotient, x_neg_ff);
                  num_in     = num_load(y_mag_ff, steps_left_ff);
                  rem_in     = '0;
                  bit_cnt_in = CNT_W'(NUM_W - 1);
                  state_in   = ST_DIV_Y;
               end else begin
                  y_incr_in = signed_incr(quotient, y_neg_ff);
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         steps_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         steps_left_ff <= steps_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      x_accum_ff   <= x_accum_in;
      y_accum_ff   <= y_accum_in;
      x_incr_ff    <= x_incr_in;
      y_incr_ff    <= y_incr_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      bit_cnt_ff   <= bit_cnt_in;
      x_neg_ff     <= x_neg_in;
      y_neg_ff     <= y_neg_in;
      y_mag_ff     <= y_mag_in;
      pix_valid_ff <= pix_valid_in;
      pix_x_ff     <= pix_x_in;
      pix_y_ff     <= pix_y_in;
      last_ff      <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_valid = pix_valid_ff;
   assign rsp_pixel_x     = pix_x_ff;
   assign rsp_pixel_y     = pix_y_ff;
   assign rsp_last_pixel  = last_ff;

   `DDA_ASSERT_NOW(a_busy_blocks_input, clock, reset, state_ff != ST_IDLE, !req_ready, "input taken while dividing")
   `DDA_ASSERT_NEXT(a_start_divides, clock, reset, req_fire && req_op == OP_START && steps != '0, state_ff == ST_DIV_X, "start with distinct endpoints did not enter division")
   `DDA_ASSERT_NEXT(a_step_last_flag, clock, reset, req_fire && req_op == OP_STEP && steps_left_ff != '0, rsp_valid && rsp_pixel_valid && (rsp_last_pixel == (steps_left_ff == '0)), "step word or last flag wrong")
   `DDA_ASSERT_NEXT(a_steps_hold_in_div, clock, reset, state_ff != ST_IDLE, $stable(steps_left_ff), "divisor changed during division")

endmodule

>>> test/dda_line_pixel_generator_tb.sv
// Self-checking testbench for the DDA line rasterizer: predicted pixel words vs. the block.
module dda_line_pixel_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dda_pkg::*;

   localparam int COORD_MAX = (1 << COORD_BITS) - 1;

   // one request word as queued for the driver, with its lead-in gap
   typedef struct {
      logic                  op;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
      int unsigned           gap;
      bit                    drain;
   } line_word_type;

   // one result word as the block should return it
   typedef struct {
      logic                  pixel_valid;
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic                  last_pixel;
   } pixel_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_op = OP_START;
   logic [COORD_BITS-1:0] req_x_start = '0;
   logic [COORD_BITS-1:0] req_y_start = '0;
   logic [COORD_BITS-1:0] req_x_end = '0;
   logic [COORD_BITS-1:0] req_y_end = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_pixel_valid;
   logic [COORD_BITS-1:0] rsp_pixel_x;
   logic [COORD_BITS-1:0] rsp_pixel_y;
   logic                  rsp_last_pixel;

   line_word_type  pending_words[$];
   pixel_word_type expected_pixels[$];
   int             error_count = 0;
   int             words_queued = 0;
   int             pixels_seen = 0;
   bit             rsp_calm = 1'b0;
   int unsigned    stall_left = 0;

   // rasterizer state as the block should hold it
   logic signed [ACC_W-1:0] col_acc = '0;
   logic signed [ACC_W-1:0] row_acc = '0;
   logic signed [INC_W-1:0] col_inc = '0;
   logic signed [INC_W-1:0] row_inc = '0;
   logic [STEP_W-1:0]       pixels_left = '0;

   dda_line_pixel_generator u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_last_pixel  (rsp_last_pixel)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs; far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Per-step slope in Q1.FRAC_BITS: delta / span, rounded half away from zero.
   function automatic logic signed [INC_W-1:0] slope_of(int delta, int span);
      longint mag;
      longint q;
      if (span == 0) return '0;
      mag = longint'((delta < 0) ? -delta : delta);
      q = ((mag << FRAC_BITS) + longint'(span / 2)) / longint'(span);
      return (delta < 0) ? INC_W'(-q) : INC_W'(q);
   endfunction

   // Truncate an accumulator to its integer part, clamped to the screen.
   function automatic logic [COORD_BITS-1:0] pixel_of(logic signed [ACC_W-1:0] acc);
      longint a;
      a = longint'(acc);
      if (a < 0) return '0;
      a = a >> FRAC_BITS;
      if (a > longint'(COORD_MAX)) return COORD_BITS'(COORD_MAX);
      return COORD_BITS'(a);
   endfunction

   // Advance the predicted rasterizer by one accepted word; return its result word.
   function automatic pixel_word_type rasterize_word(logic op, logic [COORD_BITS-1:0] xs,
                                                     logic [COORD_BITS-1:0] ys,
                                                     logic [COORD_BITS-1:0] xe,
                                                     logic [COORD_BITS-1:0] ye);
      pixel_word_type px;
      int dx;
      int dy;
      int ax;
      int ay;
      int span;
      px = '{pixel_valid: 1'b0, pixel_x: '0, pixel_y: '0, last_pixel: 1'b0};
      if (op == OP_START) begin
         // load a new line; any line in progress is dropped
         dx = int'(xe) - int'(xs);
         dy = int'(ye) - int'(ys);
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         span = (ax >= ay) ? ax : ay;
         pixels_left = STEP_W'(span);
         col_inc = slope_of(dx, span);
         row_inc = slope_of(dy, span);
         col_acc = {1'b0, xs, {FRAC_BITS{1'b0}}};
         row_acc = {1'b0, ys, {FRAC_BITS{1'b0}}};
      end else if (pixels_left != 0) begin
         // step along the line; an idle step leaves the state alone
         col_acc = col_acc + ACC_W'(col_inc);
         row_acc = row_acc + ACC_W'(row_inc);
         pixels_left = pixels_left - STEP_W'(1);
         px.pixel_valid = 1'b1;
         px.pixel_x = pixel_of(col_acc);
         px.pixel_y = pixel_of(row_acc);
         px.last_pixel = (pixels_left == 0);
      end
      return px;
   endfunction

   task automatic check_field(string name, logic [COORD_BITS-1:0] want,
                              logic [COORD_BITS-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      end
   endtask

   // Driver: hold a word until it is taken, then wait out the next word's gap
   // (and, for a drain word, every outstanding result) before presenting it.
   always @(posedge clock) begin : driver
      line_word_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         col_acc = '0;
         row_acc = '0;
         col_inc = '0;
         row_inc = '0;
         pixels_left = '0;
      end else begin
         if (req_valid && req_ready)
            expected_pixels.push_back(rasterize_word(req_op, req_x_start, req_y_start,
                                                     req_x_end, req_y_end));
         if (req_valid && !req_ready) begin
            // hold the word and its payload
         end else if (pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            nxt = pending_words[0];
            if (nxt.gap > 0) begin
               nxt.gap--;
               pending_words[0] = nxt;
               req_valid <= 1'b0;
            end else if (nxt.drain && expected_pixels.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               void'(pending_words.pop_front());
               req_op      <= nxt.op;
               req_x_start <= nxt.x_start;
               req_y_start <= nxt.y_start;
               req_x_end   <= nxt.x_end;
               req_y_end   <= nxt.y_end;
               req_valid   <= 1'b1;
            end
         end
      end
   end

   // Monitor: check each taken result word against the oldest prediction,
   // then draw how long to hold ready low before the next one.
   always @(posedge clock) begin : monitor
      pixel_word_type want;
      int unsigned s;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            error_count++;
            $display("%0t: result word with none expected, expected nothing, actual %0b/%0d/%0d/%0b",
                     $realtime, rsp_pixel_valid, rsp_pixel_x, rsp_pixel_y, rsp_last_pixel);
         end else begin
            want = expected_pixels.pop_front();
            check_field("pixel_valid", COORD_BITS'(want.pixel_valid),
                        COORD_BITS'(rsp_pixel_valid));
            check_field("pixel_x", want.pixel_x, rsp_pixel_x);
            check_field("pixel_y", want.pixel_y, rsp_pixel_y);
            check_field("last_pixel", COORD_BITS'(want.last_pixel),
                        COORD_BITS'(rsp_last_pixel));
         end
         pixels_seen++;
         // alternate stretches of back-to-back ready with stretches of stalls
         if (pixels_seen % 40 == 0) rsp_calm = ($urandom_range(0, 2) == 0);
         s = rsp_calm ? 0 : $urandom_range(0, 16);
         stall_left <= s;
         rsp_ready <= (s == 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= (stall_left == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic add_word(logic op, int xs, int ys, int xe, int ye, bit calm, bit drain);
      line_word_type w;
      w.op = op;
      w.x_start = COORD_BITS'(xs);
      w.y_start = COORD_BITS'(ys);
      w.x_end = COORD_BITS'(xe);
      w.y_end = COORD_BITS'(ye);
      w.gap = calm ? 0 : $urandom_range(0, 16);
      w.drain = drain;
      pending_words.push_back(w);
      words_queued++;
   endtask

   // Step word with junk in the ignored endpoint fields.
   task automatic add_step(bit calm);
      add_word(OP_STEP, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
               $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), calm, 1'b0);
   endtask

   function automatic int near(int c, int r);
      int v;
      v = c + int'($urandom_range(0, 2 * r)) - r;
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   initial begin : stimulus
      int  xs;
      int  ys;
      int  xe;
      int  ye;
      int  span;
      int  n;
      int  kind;
      bit  calm;
      bit  first_line;

      // step while idle right after reset
      add_word(OP_STEP, 0, 0, 0, 0, 1'b0, 1'b0);
      // equal endpoints: zero pixels, the next step is idle
      add_word(OP_START, 5, 5, 5, 5, 1'b0, 1'b0);
      add_word(OP_STEP, 0, 0, 0, 0, 1'b0, 1'b0);
      // rounding drives y just below zero on the last pixel: clamp to zero
      add_word(OP_START, 0, 2, 3, 0, 1'b1, 1'b0);
      repeat (3) add_word(OP_STEP, 0, 0, 0, 0, 1'b1, 1'b0);
      // one step past the end is idle again
      add_word(OP_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
      // full-screen diagonals, each abandoned by the next start
      add_word(OP_START, 0, 0, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
      repeat (2) add_word(OP_STEP, 0, 0, 0, 0, 1'b0, 1'b0);
      add_word(OP_START, COORD_MAX, COORD_MAX, 0, 0, 1'b1, 1'b0);
      repeat (2) add_word(OP_STEP, 0, 0, 0, 0, 1'b1, 1'b0);
      add_word(OP_START, COORD_MAX, 0, 0, COORD_MAX, 1'b0, 1'b0);
      add_word(OP_STEP, 0, 0, 0, 0, 1'b0, 1'b0);
      add_word(OP_START, 0, COORD_MAX, COORD_MAX, 0, 1'b0, 1'b0);
      add_word(OP_STEP, 0, 0, 0, 0, 1'b0, 1'b0);

      // random lines: mostly short and run to the end, some cut short or overrun
      first_line = 1'b1;
      while (words_queued < 900) begin
         calm = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 19);
         if (kind < 2) begin
            repeat ($urandom_range(1, 3)) add_step(calm);
         end else begin
            xs = $urandom_range(0, COORD_MAX);
            ys = $urandom_range(0, COORD_MAX);
            if (kind < 13) begin
               xe = near(xs, 24);
               ye = near(ys, 24);
            end else if (kind < 15) begin
               xe = (kind == 13) ? xs : near(xs, 40);
               ye = (kind == 13) ? near(ys, 40) : ys;
            end else if (kind < 16) begin
               xe = xs;
               ye = ys;
            end else begin
               xe = $urandom_range(0, COORD_MAX);
               ye = $urandom_range(0, COORD_MAX);
            end
            span = (xe > xs) ? xe - xs : xs - xe;
            if (((ye > ys) ? ye - ys : ys - ye) > span) span = (ye > ys) ? ye - ys : ys - ye;
            // drain before the first random line and now and then after
            add_word(OP_START, xs, ys, xe, ye, calm,
                     first_line || ($urandom_range(0, 59) == 0));
            first_line = 1'b0;
            if (span <= 48 || $urandom_range(0, 39) == 0)
               n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, span)
                                                : span + $urandom_range(0, 2);
            else
               n = $urandom_range(0, 24);
            repeat (n) add_step(calm);
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // wait for every word to be taken and every result checked
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_pixels.size() != 0);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/dda_pkg.sv
hdl/dda_line_pixel_generator.sv
test/dda_line_pixel_generator_tb.sv
